// ----- rtl/core/gmwf_pkg.sv -----
`default_nettype none

package gmwf_pkg;

    // Default grid size of the wall map.
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    // Width of a configuration register and its value after reset.
    localparam int CFG_W   = 9;
    localparam int CFG_RST = 256;

    // Width of a position on the ports.
    localparam int POS_W = 8;

    // Width for coordinate and count arithmetic; it covers grids up to 1024.
    localparam int EXT_W = 11;

    // Columns examined per cycle by the entrance search.
    localparam int SCAN_W = 16;

    // Operation codes of an input item.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STEP  = 2'd3;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_ENTRY = 2'd1;
    localparam logic [1:0] STATUS_STUCK    = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cell_col;
    } gmwf_req_t;

    typedef struct packed {
        logic [POS_W-1:0] path_row;
        logic [POS_W-1:0] path_col;
        logic             at_exit;
        logic [1:0]       status;
    } gmwf_res_t;

    // Completion report of the entrance search.
    typedef struct packed {
        logic done;
        logic found;
    } gmwf_scan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/gmwf_row_ram.sv -----
`default_nettype none

module gmwf_row_ram
    import gmwf_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ROWS,
    parameter int WIDTH = DEF_MAX_COLS,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    // One row of the wall map per entry; a set bit is a wall.
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: a write or a registered read in each cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gmwf_entry_scan.sv -----
`default_nettype none

module gmwf_entry_scan
    import gmwf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int CA = $clog2(MAX_COLS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [MAX_COLS-1:0]  row,
    input  logic [EXT_W-1:0]     eff_cols,
    output gmwf_scan_stat_t      stat,
    output logic [CA-1:0]        col
);

    localparam int NCH = (MAX_COLS + SCAN_W - 1) / SCAN_W;
    localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SB  = $clog2(SCAN_W);

    logic [NCH*SCAN_W-1:0] row_reg, row_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [CA-1:0]         col_reg, col_next;
    logic                  active_reg, active_next;
    gmwf_scan_stat_t       stat_reg, stat_next;

    logic [SCAN_W-1:0]     chunk;
    logic [SCAN_W-1:0]     free_vec;
    logic [EXT_W-1:0]      base;
    logic [EXT_W-1:0]      found_col;
    logic [SB-1:0]         hit_pos;
    logic                  hit;

    // Free cells of the current chunk that lie inside the columns in use.
    always_comb
    begin
        chunk = row_reg[idx_reg*SCAN_W +: SCAN_W];
        base  = EXT_W'(idx_reg) << SB;
        for (int b = 0; b < SCAN_W; b++)
        begin
            free_vec[b] = !chunk[b] && ((base + EXT_W'(b)) < eff_cols);
        end
    end

    // The highest free column of the chunk wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int b = 0; b < SCAN_W; b++)
        begin
            if (free_vec[b])
            begin
                hit     = 1'b1;
                hit_pos = SB'(b);
            end
        end
        found_col = base | EXT_W'(hit_pos);
    end

    // Walk the chunks from the rightmost one toward column zero.
    always_comb
    begin
        row_next    = row_reg;
        idx_next    = idx_reg;
        col_next    = col_reg;
        active_next = active_reg;
        stat_next   = '0;
        if (load)
        begin
            row_next                 = '1;
            row_next[MAX_COLS-1:0]   = row;
            idx_next                 = IW'(NCH - 1);
            active_next              = 1'b1;
        end
        else if (active_reg)
        begin
            if (hit)
            begin
                active_next     = 1'b0;
                stat_next.done  = 1'b1;
                stat_next.found = 1'b1;
                col_next        = found_col[CA-1:0];
            end
            else if (idx_reg == '0)
            begin
                active_next    = 1'b0;
                stat_next.done = 1'b1;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            stat_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            stat_reg   <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        idx_reg <= idx_next;
        col_reg <= col_next;
    end

    assign stat = stat_reg;
    assign col  = col_reg;

endmodule

`default_nettype wire

// ----- rtl/core/grid_maze_wall_follower_core.sv -----
// Step: the rows above, at and below the position are read one after another, then the move
//   is chosen and the result strobed; a step already on the exit row answers without a read.
// Start: row 0 is searched from the right in 16-column chunks, at most ceil(MAX_COLS/16).
// Mark wall: read and write of its row, clear maze: a write per row, neither gives a result.
// Reset clears the wall map one row per cycle; busy stays high until the map is clear.
// Results are strobed for one cycle on done; the receiver cannot stall them.
`default_nettype none

module grid_maze_wall_follower_core
    import gmwf_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  gmwf_req_t        request,
    output logic             busy,
    output logic             done,
    output gmwf_res_t        result,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [CFG_W-1:0] wr_data
);

    localparam int RA  = $clog2(MAX_ROWS);
    localparam int CA  = $clog2(MAX_COLS);
    localparam int CPW = (CA > POS_W) ? CA : POS_W;

    localparam logic [EXT_W-1:0] MAX_ROWS_EXT = EXT_W'(MAX_ROWS);
    localparam logic [EXT_W-1:0] MAX_COLS_EXT = EXT_W'(MAX_COLS);
    localparam logic [EXT_W-1:0] EFF_ROWS_RST =
        EXT_W'((CFG_RST < MAX_ROWS) ? CFG_RST : MAX_ROWS);
    localparam logic [EXT_W-1:0] EFF_COLS_RST =
        EXT_W'((CFG_RST < MAX_COLS) ? CFG_RST : MAX_COLS);

    // Register indexes of the write port.
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Headings, clockwise, and turns relative to a heading.
    localparam logic [1:0] HD_UP      = 2'd0;
    localparam logic [1:0] HD_RIGHT   = 2'd1;
    localparam logic [1:0] HD_DOWN    = 2'd2;
    localparam logic [1:0] HD_LEFT    = 2'd3;
    localparam logic [1:0] TURN_RIGHT = 2'd1;
    localparam logic [1:0] TURN_BACK  = 2'd2;
    localparam logic [1:0] TURN_LEFT  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MARK_RD,
        S_MARK_WR,
        S_SCAN_RD,
        S_SCAN_LD,
        S_SCAN,
        S_NB
    } state_t;

    state_t            state_reg, state_next;
    logic [RA-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [1:0]        nb_cnt_reg, nb_cnt_next;
    logic [POS_W-1:0]  mark_row_reg, mark_row_next;
    logic [POS_W-1:0]  mark_col_reg, mark_col_next;
    logic [POS_W-1:0]  cur_row_reg, cur_row_next;
    logic [CPW-1:0]    cur_col_reg, cur_col_next;
    logic [1:0]        heading_reg, heading_next;
    logic              free_up_reg, free_up_next;
    logic              free_left_reg, free_left_next;
    logic              free_right_reg, free_right_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    gmwf_res_t         result_reg, result_next;

    logic [EXT_W-1:0]  eff_rows_reg, eff_cols_reg;
    logic [EXT_W-1:0]  wr_ext, wr_rows_min;

    // Memory port.
    logic              ram_en, ram_we;
    logic [RA-1:0]     ram_addr;
    logic [MAX_COLS-1:0] ram_wdata, rd_data;

    // Entrance search.
    logic              scan_load;
    gmwf_scan_stat_t   scan_stat;
    logic [CA-1:0]     scan_col;

    // Neighborhood of the current position.
    logic [EXT_W-1:0]  cur_row_ext, cur_col_ext;
    logic [EXT_W-1:0]  row_m1, row_p1, col_m1, col_p1;
    logic              row_in, col_in;
    logic              in_up, in_down, in_left, in_right;
    logic              at_exit_cur, free_down;
    logic [3:0]        free_vec;
    logic              mv_found;
    logic [1:0]        mv_dir;
    logic [EXT_W-1:0]  new_row_ext, new_col_ext;

    // Wall write for a mark.
    logic [EXT_W-1:0]  req_row_ext, req_col_ext;
    logic [EXT_W-1:0]  mark_row_ext, mark_col_ext;
    logic              mark_ok;
    logic [MAX_COLS-1:0] mark_word;

    function automatic gmwf_res_t make_result(
        input logic [POS_W-1:0] row,
        input logic [CPW-1:0]   col,
        input logic [1:0]       st,
        input logic [EXT_W-1:0] eff_rows
    );
        gmwf_res_t r;
        r.path_row = row;
        r.path_col = col[POS_W-1:0];
        r.at_exit  = (EXT_W'(row) + 1'b1) >= eff_rows;
        r.status   = st;
        return r;
    endfunction

    gmwf_row_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_row_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_data)
    );

    gmwf_entry_scan #(
        .MAX_COLS (MAX_COLS)
    ) u_entry_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (scan_load),
        .row      (rd_data),
        .eff_cols (eff_cols_reg),
        .stat     (scan_stat),
        .col      (scan_col)
    );

    // Row and column counts are kept already clipped to the grid.
    assign wr_ext      = EXT_W'(wr_data);
    assign wr_rows_min = (wr_ext == '0) ? EXT_W'(1) : wr_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_rows_reg <= EFF_ROWS_RST;
            eff_cols_reg <= EFF_COLS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ROW_COUNT:
                begin
                    eff_rows_reg <= (wr_rows_min > MAX_ROWS_EXT) ? MAX_ROWS_EXT : wr_rows_min;
                end
                REG_COL_COUNT:
                begin
                    eff_cols_reg <= (wr_ext > MAX_COLS_EXT) ? MAX_COLS_EXT : wr_ext;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Neighbor coordinates and whether each lies inside the grid in use.
    always_comb
    begin
        cur_row_ext = EXT_W'(cur_row_reg);
        cur_col_ext = EXT_W'(cur_col_reg);
        row_m1      = cur_row_ext - 1'b1;
        row_p1      = cur_row_ext + 1'b1;
        col_m1      = cur_col_ext - 1'b1;
        col_p1      = cur_col_ext + 1'b1;
        row_in      = cur_row_ext < eff_rows_reg;
        col_in      = cur_col_ext < eff_cols_reg;
        in_up       = (cur_row_reg != '0) && col_in;
        in_down     = (row_p1 < eff_rows_reg) && col_in;
        in_left     = (cur_col_reg != '0) && (col_m1 < eff_cols_reg) && row_in;
        in_right    = (col_p1 < eff_cols_reg) && row_in;
        at_exit_cur = row_p1 >= eff_rows_reg;
        free_down   = in_down && !rd_data[cur_col_ext[CA-1:0]];
    end

    // Right-hand rule: right, straight, left, then back.
    always_comb
    begin
        free_vec[HD_UP]    = free_up_reg;
        free_vec[HD_RIGHT] = free_right_reg;
        free_vec[HD_DOWN]  = free_down;
        free_vec[HD_LEFT]  = free_left_reg;
        mv_found = 1'b1;
        if (free_vec[heading_reg + TURN_RIGHT])
        begin
            mv_dir = heading_reg + TURN_RIGHT;
        end
        else if (free_vec[heading_reg])
        begin
            mv_dir = heading_reg;
        end
        else if (free_vec[heading_reg + TURN_LEFT])
        begin
            mv_dir = heading_reg + TURN_LEFT;
        end
        else if (free_vec[heading_reg + TURN_BACK])
        begin
            mv_dir = heading_reg + TURN_BACK;
        end
        else
        begin
            mv_found = 1'b0;
            mv_dir   = heading_reg;
        end
    end

    // Position after the move.
    always_comb
    begin
        new_row_ext = cur_row_ext;
        new_col_ext = cur_col_ext;
        case (mv_dir)
            HD_UP:    new_row_ext = row_m1;
            HD_DOWN:  new_row_ext = row_p1;
            HD_RIGHT: new_col_ext = col_p1;
            HD_LEFT:  new_col_ext = col_m1;
            default:
            begin
            end
        endcase
    end

    // Mark address and the wall bit it sets.
    always_comb
    begin
        req_row_ext  = EXT_W'(request.cell_row);
        req_col_ext  = EXT_W'(request.cell_col);
        mark_ok      = (req_row_ext < MAX_ROWS_EXT) && (req_col_ext < MAX_COLS_EXT);
        mark_row_ext = EXT_W'(mark_row_reg);
        mark_col_ext = EXT_W'(mark_col_reg);
        mark_word    = '0;
        mark_word[mark_col_ext[CA-1:0]] = 1'b1;
    end

    // Sequencer: memory port control and position update.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        nb_cnt_next     = nb_cnt_reg;
        mark_row_next   = mark_row_reg;
        mark_col_next   = mark_col_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        heading_next    = heading_reg;
        free_up_next    = free_up_reg;
        free_left_next  = free_left_reg;
        free_right_next = free_right_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = '0;
        ram_wdata       = '0;
        scan_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.operation)
                        OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        OP_MARK:
                        begin
                            mark_row_next = request.cell_row;
                            mark_col_next = request.cell_col;
                            if (mark_ok)
                            begin
                                state_next = S_MARK_RD;
                            end
                        end
                        OP_START:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        OP_STEP:
                        begin
                            if (at_exit_cur)
                            begin
                                done_next   = 1'b1;
                                result_next = make_result(cur_row_reg, cur_col_reg,
                                                          STATUS_OK, eff_rows_reg);
                            end
                            else
                            begin
                                nb_cnt_next = '0;
                                state_next  = S_NB;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
                if (clr_cnt_reg == RA'(MAX_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_MARK_RD:
            begin
                ram_en     = 1'b1;
                ram_addr   = mark_row_ext[RA-1:0];
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = mark_row_ext[RA-1:0];
                ram_wdata  = rd_data | mark_word;
                state_next = S_IDLE;
            end

            S_SCAN_RD:
            begin
                ram_en     = 1'b1;
                ram_addr   = '0;
                state_next = S_SCAN_LD;
            end

            S_SCAN_LD:
            begin
                scan_load  = 1'b1;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    cur_row_next = '0;
                    heading_next = HD_DOWN;
                    cur_col_next = scan_stat.found ? CPW'(scan_col) : '0;
                    done_next    = 1'b1;
                    result_next  = make_result('0,
                                               scan_stat.found ? CPW'(scan_col) : '0,
                                               scan_stat.found ? STATUS_OK : STATUS_NO_ENTRY,
                                               eff_rows_reg);
                    state_next   = S_IDLE;
                end
            end

            S_NB:
            begin
                nb_cnt_next = nb_cnt_reg + 1'b1;
                case (nb_cnt_reg)
                    2'd0:
                    begin
                        ram_en   = 1'b1;
                        ram_addr = row_m1[RA-1:0];
                    end
                    2'd1:
                    begin
                        ram_en       = 1'b1;
                        ram_addr     = cur_row_ext[RA-1:0];
                        free_up_next = in_up && !rd_data[cur_col_ext[CA-1:0]];
                    end
                    2'd2:
                    begin
                        ram_en          = 1'b1;
                        ram_addr        = row_p1[RA-1:0];
                        free_left_next  = in_left && !rd_data[col_m1[CA-1:0]];
                        free_right_next = in_right && !rd_data[col_p1[CA-1:0]];
                    end
                    2'd3:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (mv_found)
                        begin
                            cur_row_next = new_row_ext[POS_W-1:0];
                            cur_col_next = CPW'(new_col_ext[POS_W-1:0]);
                            heading_next = mv_dir;
                            result_next  = make_result(new_row_ext[POS_W-1:0],
                                                       CPW'(new_col_ext[POS_W-1:0]),
                                                       STATUS_OK, eff_rows_reg);
                        end
                        else
                        begin
                            result_next = make_result(cur_row_reg, cur_col_reg,
                                                      STATUS_STUCK, eff_rows_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        busy_next = (state_next != S_IDLE);
    end

    // State, position and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            nb_cnt_reg     <= '0;
            mark_row_reg   <= '0;
            mark_col_reg   <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            heading_reg    <= HD_DOWN;
            free_up_reg    <= 1'b0;
            free_left_reg  <= 1'b0;
            free_right_reg <= 1'b0;
            busy_reg       <= 1'b1;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            nb_cnt_reg     <= nb_cnt_next;
            mark_row_reg   <= mark_row_next;
            mark_col_reg   <= mark_col_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            heading_reg    <= heading_next;
            free_up_reg    <= free_up_next;
            free_left_reg  <= free_left_next;
            free_right_reg <= free_right_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gmwf_checker.sv -----
`default_nettype none

module gmwf_checker
    import gmwf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  gmwf_req_t        request,
    input  logic             busy,
    input  logic             done,
    input  gmwf_res_t        result
);

    // A result is strobed only as the block goes idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // Every result follows an accepted item or a busy stretch.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without an item in flight");

    // Status is one of the defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STATUS_OK || result.status == STATUS_NO_ENTRY ||
                  result.status == STATUS_STUCK))
        else $error("undefined status code");

    // A failed start parks the walker at the origin.
    a_no_entry_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_NO_ENTRY) |->
            (result.path_row == '0 && result.path_col == '0))
        else $error("no entrance reported away from the origin");

    // Clearing and marking give no result.
    a_silent_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.operation == OP_CLEAR || request.operation == OP_MARK))
            |=> !done)
        else $error("result after clear or mark");

endmodule

bind grid_maze_wall_follower_core gmwf_checker u_gmwf_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire

// ----- tb/sv/grid_maze_wall_follower_core_tb.sv -----
`timescale 1ns / 1ps

module grid_maze_wall_follower_core_tb;
    import gmwf_pkg::*;

    localparam int GRID_ROWS = DEF_MAX_ROWS;
    localparam int GRID_COLS = DEF_MAX_COLS;

    // Configuration register indexes.
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // A clear keeps the block busy while it writes every row; allow some margin.
    localparam int CLEAR_CYCLES = GRID_ROWS + 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;

    // Headings in clockwise order.
    typedef enum logic [1:0] {HD_UP, HD_RIGHT, HD_DOWN, HD_LEFT} heading_e;

    // One line of the directed table: either an item or a new grid size.
    typedef struct packed {
        bit               is_cfg;
        logic [1:0]       op;
        logic [7:0]       row;
        logic [7:0]       col;
        logic [CFG_W-1:0] rows_cfg;
        logic [CFG_W-1:0] cols_cfg;
        bit               typed;
        gmwf_res_t        res;
    } stim_row_t;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             start    = 1'b0;
    gmwf_req_t        request  = '0;
    logic             busy;
    logic             done;
    gmwf_res_t        result;
    logic             wr_en    = 1'b0;
    logic             wr_index = 1'b0;
    logic [CFG_W-1:0] wr_data  = '0;

    grid_maze_wall_follower_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Walker state as the testbench sees it.
    bit [GRID_COLS-1:0] wall_rows [GRID_ROWS];
    logic [7:0]         walker_row;
    logic [7:0]         walker_col;
    heading_e           walker_hdg;
    logic [CFG_W-1:0]   row_count_q;
    logic [CFG_W-1:0]   col_count_q;

    gmwf_res_t expected_pos [$];
    gmwf_res_t last_pos;
    gmwf_res_t want_pos;
    stim_row_t directed [$];
    int        errors      = 0;
    int        burst_left  = 0;
    int        sent_items  = 0;
    int        stall_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Rows in use: zero counts as one, anything above the map is clipped.
    function automatic int live_rows();
        int n;
        n = row_count_q;
        if (n == 0)
            n = 1;
        if (n > GRID_ROWS)
            n = GRID_ROWS;
        return n;
    endfunction

    function automatic int live_cols();
        int n;
        n = col_count_q;
        if (n > GRID_COLS)
            n = GRID_COLS;
        return n;
    endfunction

    // Cells outside the grid in use read as walls.
    function automatic bit is_open(int r, int c);
        if (r < 0 || c < 0 || r >= live_rows() || c >= live_cols())
            return 1'b0;
        return !wall_rows[r][c];
    endfunction

    function automatic gmwf_res_t position(logic [1:0] st);
        gmwf_res_t p;
        p.path_row = walker_row;
        p.path_col = walker_col;
        p.at_exit  = (int'(walker_row) >= live_rows() - 1);
        p.status   = st;
        return p;
    endfunction

    // Applies one item to the walker; returns 1 when the item yields a position.
    function automatic bit walk_model(input gmwf_req_t item, output gmwf_res_t res);
        int       found;
        int       nr;
        int       nc;
        heading_e h;
        res = '0;
        case (item.operation)
            OP_CLEAR:
            begin
                foreach (wall_rows[r])
                    wall_rows[r] = '0;
                return 1'b0;
            end
            OP_MARK:
            begin
                wall_rows[item.cell_row][item.cell_col] = 1'b1;
                return 1'b0;
            end
            OP_START:
            begin
                // The entrance is the rightmost free cell of the top row.
                found = -1;
                for (int j = 0; j < live_cols(); j++)
                    if (is_open(0, j))
                        found = j;
                walker_row = '0;
                walker_col = (found < 0) ? 8'd0 : found[7:0];
                walker_hdg = HD_DOWN;
                res = position((found < 0) ? STATUS_NO_ENTRY : STATUS_OK);
                return 1'b1;
            end
            OP_STEP:
            begin
                // Nothing moves once the exit row is reached.
                if (int'(walker_row) >= live_rows() - 1)
                begin
                    res = position(STATUS_OK);
                    return 1'b1;
                end
                // Try right, straight, left, back: turn offsets 1, 0, 3, 2 are (5 - k) mod 4.
                for (int k = 0; k < 4; k++)
                begin
                    h  = heading_e'(2'(int'(walker_hdg) + 5 - k));
                    nr = int'(walker_row) + ((h == HD_DOWN) ? 1 : 0) - ((h == HD_UP) ? 1 : 0);
                    nc = int'(walker_col) + ((h == HD_RIGHT) ? 1 : 0) - ((h == HD_LEFT) ? 1 : 0);
                    if (is_open(nr, nc))
                    begin
                        walker_row = nr[7:0];
                        walker_col = nc[7:0];
                        walker_hdg = h;
                        res = position(STATUS_OK);
                        return 1'b1;
                    end
                end
                res = position(STATUS_STUCK);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Holds the sender off until every expected position has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (expected_pos.size() != 0);
    endtask

    // Sends one item in bursts with random gaps, and records what it should yield.
    task automatic send_item(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
                             input bit typed, input gmwf_res_t typed_res);
        gmwf_req_t item;
        gmwf_res_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 6));
        end
        burst_left--;
        item.operation = op;
        item.cell_row  = r;
        item.cell_col  = c;
        start   <= 1'b1;
        request <= item;
        do @(posedge clk); while (busy);
        sent_items++;
        if (walk_model(item, res))
        begin
            last_pos = res;
            expected_pos.push_back(typed ? typed_res : res);
        end
    endtask

    // Writes both grid sizes once the block has gone quiet.
    task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        drain();
        repeat (CLEAR_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_ROW_COUNT;
        wr_data  <= rows;
        @(posedge clk);
        row_count_q = rows;
        wr_index <= REG_COL_COUNT;
        wr_data  <= cols;
        @(posedge clk);
        col_count_q = cols;
        wr_en <= 1'b0;
    endtask

    function automatic stim_row_t item_row(logic [1:0] op, logic [7:0] r, logic [7:0] c);
        stim_row_t s;
        s = '0;
        s.op  = op;
        s.row = r;
        s.col = c;
        return s;
    endfunction

    function automatic stim_row_t typed_row(logic [1:0] op, gmwf_res_t res);
        stim_row_t s;
        s = item_row(op, 8'd0, 8'd0);
        s.typed = 1'b1;
        s.res   = res;
        return s;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        stim_row_t s;
        s = '0;
        s.is_cfg   = 1'b1;
        s.rows_cfg = rows;
        s.cols_cfg = cols;
        return s;
    endfunction

    // Scatters walls over the grid in use, about three cells in ten, at most 60.
    task automatic fill_walls();
        int n;
        n = live_rows() * live_cols() * 3 / 10;
        if (n > 60)
            n = 60;
        repeat (n)
            send_item(OP_MARK, 8'($urandom_range(0, live_rows() - 1)),
                      (live_cols() == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, live_cols() - 1)),
                      1'b0, '0);
    endtask

    // A start followed by steps and the odd mark; it usually ends at the exit or when stuck.
    task automatic walk();
        int steps;
        steps = $urandom_range(1, 60);
        send_item(OP_START, 8'($urandom), 8'($urandom), 1'b0, '0);
        for (int i = 0; i < steps; i++)
        begin
            if ((last_pos.at_exit || last_pos.status != STATUS_OK) && $urandom_range(0, 3) != 0)
                break;
            if ($urandom_range(0, 99) < 3)
                send_item(OP_MARK, 8'($urandom_range(0, live_rows() - 1)), 8'($urandom),
                          1'b0, '0);
            send_item(OP_STEP, 8'($urandom), 8'($urandom), 1'b0, '0);
        end
    endtask

    // Each result is compared with the oldest expected position.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pos.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, got %p", $time, result);
            end
            else
            begin
                want_pos = expected_pos.pop_front();
                if (result.path_row !== want_pos.path_row)
                begin
                    errors++;
                    $display("%0t: path_row expected %0d got %0d",
                             $time, want_pos.path_row, result.path_row);
                end
                if (result.path_col !== want_pos.path_col)
                begin
                    errors++;
                    $display("%0t: path_col expected %0d got %0d",
                             $time, want_pos.path_col, result.path_col);
                end
                if (result.at_exit !== want_pos.at_exit)
                begin
                    errors++;
                    $display("%0t: at_exit expected %0d got %0d",
                             $time, want_pos.at_exit, result.at_exit);
                end
                if (result.status !== want_pos.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want_pos.status, result.status);
                end
            end
        end
    end

    // Ends the run when nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("grid_maze_wall_follower_core_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int target;
        int pick;

        walker_row  = '0;
        walker_col  = '0;
        walker_hdg  = HD_DOWN;
        row_count_q = CFG_RST;
        col_count_q = CFG_RST;

        // Directed part: reset state, extremes and each corner case of the walk.
        directed.push_back(typed_row(OP_STEP, gmwf_res_t'{8'd1, 8'd0, 1'b0, STATUS_OK}));
        directed.push_back(typed_row(OP_START, gmwf_res_t'{8'd0, 8'd255, 1'b0, STATUS_OK}));
        directed.push_back(item_row(OP_MARK, 8'd255, 8'd255));
        directed.push_back(item_row(OP_MARK, 8'd0, 8'd255));
        directed.push_back(typed_row(OP_START, gmwf_res_t'{8'd0, 8'd254, 1'b0, STATUS_OK}));
        directed.push_back(item_row(OP_STEP, 8'd0, 8'd0));
        directed.push_back(item_row(OP_CLEAR, 8'd0, 8'd0));
        // A zero row count makes row 0 the exit, so a step stays put.
        directed.push_back(cfg_row(9'd0, 9'd256));
        directed.push_back(typed_row(OP_STEP, gmwf_res_t'{8'd0, 8'd253, 1'b1, STATUS_OK}));
        directed.push_back(typed_row(OP_START, gmwf_res_t'{8'd0, 8'd255, 1'b1, STATUS_OK}));
        // No columns leaves no entrance.
        directed.push_back(cfg_row(9'd0, 9'd0));
        directed.push_back(typed_row(OP_START, gmwf_res_t'{8'd0, 8'd0, 1'b1, STATUS_NO_ENTRY}));
        // Three by three grid: a walled-in entrance is stuck, a full top row has no entrance.
        directed.push_back(cfg_row(9'd3, 9'd3));
        directed.push_back(item_row(OP_MARK, 8'd0, 8'd1));
        directed.push_back(item_row(OP_MARK, 8'd1, 8'd2));
        directed.push_back(typed_row(OP_START, gmwf_res_t'{8'd0, 8'd2, 1'b0, STATUS_OK}));
        directed.push_back(typed_row(OP_STEP, gmwf_res_t'{8'd0, 8'd2, 1'b0, STATUS_STUCK}));
        directed.push_back(item_row(OP_MARK, 8'd0, 8'd0));
        directed.push_back(item_row(OP_MARK, 8'd0, 8'd2));
        directed.push_back(typed_row(OP_START, gmwf_res_t'{8'd0, 8'd0, 1'b0, STATUS_NO_ENTRY}));
        directed.push_back(item_row(OP_STEP, 8'd0, 8'd0));
        directed.push_back(item_row(OP_STEP, 8'd0, 8'd0));
        directed.push_back(item_row(OP_STEP, 8'd0, 8'd0));
        // Counts above the map are clipped to it.
        directed.push_back(cfg_row(9'd511, 9'd511));
        directed.push_back(item_row(OP_STEP, 8'd0, 8'd0));
        directed.push_back(item_row(OP_MARK, 8'd255, 8'd0));
        directed.push_back(typed_row(OP_START, gmwf_res_t'{8'd0, 8'd255, 1'b0, STATUS_OK}));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                set_grid(directed[i].rows_cfg, directed[i].cols_cfg);
            else
                send_item(directed[i].op, directed[i].row, directed[i].col,
                          directed[i].typed, directed[i].res);
        end

        // Random part: a few fixed grid sizes, then small random mazes.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_grid(9'd256, 9'd256);
                1: set_grid(9'd1, 9'd1);
                2: set_grid(9'd511, 9'd300);
                3: set_grid(9'd2, 9'd0);
                default: set_grid(9'($urandom_range(2, 14)), 9'($urandom_range(1, 14)));
            endcase
            send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 1'b0, '0);
            fill_walls();
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    walk();
                else if (pick < 85)
                    fill_walls();
                else if (pick < 92)
                    send_item(OP_MARK, 8'($urandom), 8'($urandom), 1'b0, '0);
                else if (pick < 96)
                    send_item(OP_STEP, 8'($urandom), 8'($urandom), 1'b0, '0);
                else if (pick < 97)
                begin
                    send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 1'b0, '0);
                    fill_walls();
                end
                else
                    drain();
            end
        end

        drain();
        repeat (CLEAR_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("grid_maze_wall_follower_core_tb OK");
        else
            $display("grid_maze_wall_follower_core_tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gmwf_pkg.sv
rtl/core/gmwf_row_ram.sv
rtl/core/gmwf_entry_scan.sv
rtl/core/grid_maze_wall_follower_core.sv
rtl/core/gmwf_checker.sv
tb/sv/grid_maze_wall_follower_core_tb.sv
